// ===== rtl/core/vwi_pkg.sv =====
// ----------------------------------------------------------------------------
// vwi_pkg: shared types and constants of the vertex weld indexer
// Field widths, register indexes and the controller/datapath command structs.
// ----------------------------------------------------------------------------
package vwi_pkg;

    localparam int VERTEX_DEPTH = 1024;
    localparam int VIDX_W       = $clog2(VERTEX_DEPTH);
    localparam int VCNT_W       = VIDX_W + 1;

    localparam int POS_W  = 32;
    localparam int TEX_W  = 24;
    localparam int ICNT_W = 24;

    localparam logic [ICNT_W-1:0] ICNT_MAX = '1;

    typedef enum logic [2:0] {
        REG_OFFSET_U = 3'd0,
        REG_OFFSET_V = 3'd1,
        REG_SCALE_U  = 3'd2,
        REG_SCALE_V  = 3'd3,
        REG_VCAP     = 3'd4,
        REG_ICAP     = 3'd5,
        REG_POS_TOL  = 3'd6,
        REG_TEX_TOL  = 3'd7
    } reg_index_t;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    // controller -> datapath
    typedef struct packed {
        logic load;      // capture the accepted transaction
        logic remap;     // register the remapped uv
        logic rd_issue;  // read entry at scan pointer
        logic cmp;       // evaluate the entry read the cycle before
        logic finish;    // form the result and update the counts
    } vwi_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic is_clear;
        logic scan_empty;  // no stored entries to search
        logic last_issue;  // scan pointer is at the last stored entry
        logic hit;         // compared entry matched
    } vwi_status_t;

endpackage

// ===== rtl/core/vwi_if.sv =====
// ----------------------------------------------------------------------------
// vwi_in_if / vwi_out_if / vwi_cfg_if: channel interfaces
// Valid/ready channels for input vertices, results and register writes.
// ----------------------------------------------------------------------------
interface vwi_in_if
    import vwi_pkg::*;
;
    logic                    valid;
    logic                    ready;
    logic                    func;
    logic signed [POS_W-1:0] pos_x;
    logic signed [POS_W-1:0] pos_y;
    logic signed [POS_W-1:0] pos_z;
    logic signed [TEX_W-1:0] tex_u;
    logic signed [TEX_W-1:0] tex_v;

    modport source (output valid, func, pos_x, pos_y, pos_z, tex_u, tex_v, input ready);
    modport sink   (input valid, func, pos_x, pos_y, pos_z, tex_u, tex_v, output ready);
endinterface

interface vwi_out_if
    import vwi_pkg::*;
;
    logic                     valid;
    logic                     ready;
    logic [VIDX_W-1:0]        vertex_index;
    logic                     reused;
    logic [ICNT_W-1:0]        index_position;
    logic                     index_overflow;
    logic                     vertex_overflow;
    logic signed [POS_W-1:0]  out_x;
    logic signed [POS_W-1:0]  out_y;
    logic signed [POS_W-1:0]  out_z;
    logic signed [TEX_W-1:0]  out_u;
    logic signed [TEX_W-1:0]  out_v;
    logic [ICNT_W-1:0]        index_total;

    modport source (output valid, vertex_index, reused, index_position, index_overflow,
                    vertex_overflow, out_x, out_y, out_z, out_u, out_v, index_total,
                    input ready);
    modport sink   (input valid, vertex_index, reused, index_position, index_overflow,
                    vertex_overflow, out_x, out_y, out_z, out_u, out_v, index_total,
                    output ready);
endinterface

interface vwi_cfg_if
    import vwi_pkg::*;
;
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

// ===== rtl/core/vwi_ram.sv =====
// ----------------------------------------------------------------------------
// vwi_ram: generic single-port RAM
// One write or read per cycle, registered read data.
// ----------------------------------------------------------------------------
module vwi_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end
endmodule

// ===== rtl/core/vwi_ctrl.sv =====
// ----------------------------------------------------------------------------
// vwi_ctrl: sequencer of the vertex weld indexer
// Steps one transaction through load, remap, table scan and result.
// ----------------------------------------------------------------------------
module vwi_ctrl
    import vwi_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    output logic        out_valid,
    input  logic        out_ready,
    input  vwi_status_t status,
    output vwi_cmd_t    cmd
);
    typedef enum logic [5:0] {
        ST_IDLE  = 6'b000001,
        ST_REMAP = 6'b000010,
        ST_SCAN  = 6'b000100,
        ST_DRAIN = 6'b001000,
        ST_DONE  = 6'b010000,
        ST_OUT   = 6'b100000
    } state_t;

    state_t state_reg, state_next;

    assign in_ready  = (state_reg == ST_IDLE);
    assign out_valid = (state_reg == ST_OUT);

    always_comb
    begin
        state_next   = state_reg;
        cmd          = '0;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_REMAP;
                end
            end
            ST_REMAP:
            begin
                cmd.remap = 1'b1;
                if (status.is_clear || status.scan_empty)
                begin
                    state_next = ST_DONE;
                end
                else
                begin
                    cmd.rd_issue = 1'b1;
                    state_next   = status.last_issue ? ST_DRAIN : ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                // compare previous read while the next one is issued
                cmd.cmp = 1'b1;
                if (status.hit)
                begin
                    state_next = ST_DONE;
                end
                else
                begin
                    cmd.rd_issue = 1'b1;
                    state_next   = status.last_issue ? ST_DRAIN : ST_SCAN;
                end
            end
            ST_DRAIN:
            begin
                cmd.cmp    = 1'b1;
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                cmd.finish = 1'b1;
                state_next = ST_OUT;
            end
            ST_OUT:
            begin
                if (out_ready)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end
endmodule

// ===== rtl/core/vwi_dp.sv =====
// ----------------------------------------------------------------------------
// vwi_dp: datapath of the vertex weld indexer
// Configuration, remap multipliers, vertex tables, match compare, counts.
// ----------------------------------------------------------------------------
module vwi_dp
    import vwi_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    cfg_we,
    input  logic [CFG_IDX_W-1:0]    cfg_index,
    input  logic [CFG_DATA_W-1:0]   cfg_data,
    input  logic                    in_func,
    input  logic signed [POS_W-1:0] in_x,
    input  logic signed [POS_W-1:0] in_y,
    input  logic signed [POS_W-1:0] in_z,
    input  logic signed [TEX_W-1:0] in_u,
    input  logic signed [TEX_W-1:0] in_v,
    input  vwi_cmd_t                cmd,
    output vwi_status_t             status,
    output logic [VIDX_W-1:0]       r_vidx,
    output logic                    r_reused,
    output logic [ICNT_W-1:0]       r_ipos,
    output logic                    r_iovf,
    output logic                    r_vovf,
    output logic signed [POS_W-1:0] r_x,
    output logic signed [POS_W-1:0] r_y,
    output logic signed [POS_W-1:0] r_z,
    output logic signed [TEX_W-1:0] r_u,
    output logic signed [TEX_W-1:0] r_v,
    output logic [ICNT_W-1:0]       r_itotal
);
    // configuration
    logic signed [TEX_W-1:0] off_u_reg, off_v_reg, scl_u_reg, scl_v_reg;
    logic [VCNT_W-1:0]       vcap_reg;
    logic [15:0]             icap_reg;
    logic [31:0]             ptol_reg, ttol_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            off_u_reg <= '0;
            off_v_reg <= '0;
            scl_u_reg <= TEX_W'(65536);
            scl_v_reg <= TEX_W'(65536);
            vcap_reg  <= VCNT_W'(1024);
            icap_reg  <= 16'd65535;
            ptol_reg  <= 32'd53084;
            ttol_reg  <= 32'd4295;
        end
        else if (cfg_we)
        begin
            case (reg_index_t'(cfg_index))
                REG_OFFSET_U: off_u_reg <= cfg_data[TEX_W-1:0];
                REG_OFFSET_V: off_v_reg <= cfg_data[TEX_W-1:0];
                REG_SCALE_U:  scl_u_reg <= cfg_data[TEX_W-1:0];
                REG_SCALE_V:  scl_v_reg <= cfg_data[TEX_W-1:0];
                REG_VCAP:     vcap_reg  <= cfg_data[VCNT_W-1:0];
                REG_ICAP:     icap_reg  <= cfg_data[15:0];
                REG_POS_TOL:  ptol_reg  <= cfg_data;
                REG_TEX_TOL:  ttol_reg  <= cfg_data;
                default:      ;
            endcase
        end
    end

    // captured item, payload only
    logic                    func_reg;
    logic signed [POS_W-1:0] x_reg, y_reg, z_reg;
    logic signed [47:0]      pu_reg, pv_reg;
    logic signed [TEX_W-1:0] u_reg, v_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            func_reg <= in_func;
            x_reg    <= in_x;
            y_reg    <= in_y;
            z_reg    <= in_z;
            pu_reg   <= 48'(in_u * scl_u_reg);
            pv_reg   <= 48'(in_v * scl_v_reg);
        end
    end

    function automatic logic signed [TEX_W-1:0] finish_remap(
        input logic signed [47:0]      p,
        input logic signed [TEX_W-1:0] off
    );
        logic signed [33:0] r;
        r = 34'(((p + 48'sd32768) >>> 16)) + 34'(off);
        if (r > 34'sd8388607)
        begin
            return TEX_W'(24'sh7FFFFF);
        end
        else if (r < -34'sd8388608)
        begin
            return TEX_W'(24'sh800000);
        end
        return r[TEX_W-1:0];
    endfunction

    always_ff @(posedge clk)
    begin
        if (cmd.remap)
        begin
            u_reg <= finish_remap(pu_reg, off_u_reg);
            v_reg <= finish_remap(pv_reg, off_v_reg);
        end
    end

    // counts and scan pointer
    logic [VCNT_W-1:0] vcnt_reg;
    logic [ICNT_W-1:0] icnt_reg;
    logic [VCNT_W-1:0] ptr_reg;   // next entry to read
    logic [VIDX_W-1:0] cmp_idx_reg;

    // table rams
    logic              we;
    logic [VIDX_W-1:0] addr;
    logic [POS_W-1:0]  sx, sz;
    logic [TEX_W-1:0]  su, sv;

    vwi_ram #(.WIDTH(POS_W), .DEPTH(VERTEX_DEPTH)) u_ram_x
        (.clk(clk), .we(we), .addr(addr), .wdata(x_reg), .rdata(sx));
    vwi_ram #(.WIDTH(POS_W), .DEPTH(VERTEX_DEPTH)) u_ram_z
        (.clk(clk), .we(we), .addr(addr), .wdata(z_reg), .rdata(sz));
    vwi_ram #(.WIDTH(TEX_W), .DEPTH(VERTEX_DEPTH)) u_ram_u
        (.clk(clk), .we(we), .addr(addr), .wdata(u_reg), .rdata(su));
    vwi_ram #(.WIDTH(TEX_W), .DEPTH(VERTEX_DEPTH)) u_ram_v
        (.clk(clk), .we(we), .addr(addr), .wdata(v_reg), .rdata(sv));

    // per-axis near test: |d| below 2^16 and sum of squares below tolerance
    function automatic logic near2(
        input logic signed [POS_W:0] a,
        input logic signed [POS_W:0] b,
        input logic [31:0]           tol
    );
        logic [POS_W:0] ma, mb;
        logic [32:0]    s;
        ma = a[POS_W] ? POS_W'(0) - a : a;
        mb = b[POS_W] ? POS_W'(0) - b : b;
        if (ma[POS_W:16] != '0 || mb[POS_W:16] != '0)
        begin
            return 1'b0;
        end
        s = 33'(ma[15:0] * ma[15:0]) + 33'(mb[15:0] * mb[15:0]);
        return s < 33'(tol);
    endfunction

    logic hit;
    assign hit = near2((POS_W+1)'($signed(sx)) - (POS_W+1)'(x_reg),
                       (POS_W+1)'($signed(sz)) - (POS_W+1)'(z_reg), ptol_reg)
              && near2((POS_W+1)'($signed(su)) - (POS_W+1)'(u_reg),
                       (POS_W+1)'($signed(sv)) - (POS_W+1)'(v_reg), ttol_reg);

    logic [VCNT_W-1:0] limit;
    logic              store_new;
    logic              found_reg;
    logic [VIDX_W-1:0] found_idx_reg;

    assign limit     = (vcap_reg < VCNT_W'(VERTEX_DEPTH)) ? vcap_reg : VCNT_W'(VERTEX_DEPTH);
    assign store_new = cmd.finish && !func_reg && !found_reg && (vcnt_reg < limit);
    assign we        = store_new;
    assign addr      = store_new ? vcnt_reg[VIDX_W-1:0] : ptr_reg[VIDX_W-1:0];

    assign status.is_clear   = func_reg;
    assign status.scan_empty = (vcnt_reg == '0);
    assign status.last_issue = (ptr_reg + 1'b1 == vcnt_reg);
    assign status.hit        = cmd.cmp && hit;

    always_ff @(posedge clk)
    begin
        if (cmd.rd_issue)
        begin
            cmp_idx_reg <= ptr_reg[VIDX_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vcnt_reg      <= '0;
            icnt_reg      <= '0;
            ptr_reg       <= '0;
            found_reg     <= 1'b0;
            found_idx_reg <= '0;
        end
        else
        begin
            if (cmd.load)
            begin
                ptr_reg   <= '0;
                found_reg <= 1'b0;
            end
            if (cmd.rd_issue)
            begin
                ptr_reg <= ptr_reg + 1'b1;
            end
            if (cmd.cmp && hit)
            begin
                found_reg     <= 1'b1;
                found_idx_reg <= cmp_idx_reg;
            end
            if (cmd.finish)
            begin
                if (func_reg)
                begin
                    vcnt_reg <= '0;
                    icnt_reg <= '0;
                end
                else
                begin
                    if (store_new)
                    begin
                        vcnt_reg <= vcnt_reg + 1'b1;
                    end
                    if (icnt_reg != ICNT_MAX)
                    begin
                        icnt_reg <= icnt_reg + 1'b1;
                    end
                end
            end
        end
    end

    // result register
    always_ff @(posedge clk)
    begin
        if (cmd.finish)
        begin
            r_vidx   <= '0;
            r_reused <= 1'b0;
            r_ipos   <= '0;
            r_iovf   <= 1'b0;
            r_vovf   <= 1'b0;
            r_x      <= '0;
            r_y      <= '0;
            r_z      <= '0;
            r_u      <= '0;
            r_v      <= '0;
            r_itotal <= '0;
            if (!func_reg)
            begin
                r_ipos   <= icnt_reg;
                r_iovf   <= (icnt_reg >= ICNT_W'(icap_reg));
                r_itotal <= (icnt_reg != ICNT_MAX) ? icnt_reg + 1'b1 : icnt_reg;
                if (found_reg)
                begin
                    r_vidx   <= found_idx_reg;
                    r_reused <= 1'b1;
                end
                else if (store_new)
                begin
                    r_vidx <= vcnt_reg[VIDX_W-1:0];
                    r_x    <= x_reg;
                    r_y    <= y_reg;
                    r_z    <= z_reg;
                    r_u    <= u_reg;
                    r_v    <= v_reg;
                end
                else
                begin
                    r_vovf <= 1'b1;
                end
            end
        end
    end
endmodule

// ===== rtl/core/vertex_weld_indexer.sv =====
// ----------------------------------------------------------------------------
// vertex_weld_indexer: vertex welding index generator
// Deduplicates vertices by x/z position and remapped uv, emits one index each.
// ----------------------------------------------------------------------------
// One transaction at a time. An add transaction takes the load and remap
// cycles, then a scan of the stored table that reads one entry per cycle
// from single-port RAMs (x, z, u, v), then a finish step that forms the
// result and appends a new vertex if no match was found and there is room.
// The scan covers up to N stored vertices (N up to VERTEX_DEPTH = 1024) and
// stops early when a match is found; a clear or an add to an empty table
// skips the scan. The result stays in its register until taken, and the
// next input is accepted after that. Tables need no clearing after reset:
// only entries below the vertex count are ever read.
module vertex_weld_indexer
    import vwi_pkg::*;
(
    input logic       clk,
    input logic       rst_n,
    vwi_cfg_if.sink   cfg,
    vwi_in_if.sink    in_ch,
    vwi_out_if.source out_ch
);
    vwi_cmd_t    cmd;
    vwi_status_t status;

    // configuration writes are always taken
    assign cfg.ready = 1'b1;

    vwi_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_ch.valid),
        .in_ready  (in_ch.ready),
        .out_valid (out_ch.valid),
        .out_ready (out_ch.ready),
        .status    (status),
        .cmd       (cmd)
    );

    vwi_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg.valid),
        .cfg_index (cfg.index),
        .cfg_data  (cfg.data),
        .in_func   (in_ch.func),
        .in_x      (in_ch.pos_x),
        .in_y      (in_ch.pos_y),
        .in_z      (in_ch.pos_z),
        .in_u      (in_ch.tex_u),
        .in_v      (in_ch.tex_v),
        .cmd       (cmd),
        .status    (status),
        .r_vidx    (out_ch.vertex_index),
        .r_reused  (out_ch.reused),
        .r_ipos    (out_ch.index_position),
        .r_iovf    (out_ch.index_overflow),
        .r_vovf    (out_ch.vertex_overflow),
        .r_x       (out_ch.out_x),
        .r_y       (out_ch.out_y),
        .r_z       (out_ch.out_z),
        .r_u       (out_ch.out_u),
        .r_v       (out_ch.out_v),
        .r_itotal  (out_ch.index_total)
    );

    // never accept and present at the same time
    assert property (@(posedge clk) disable iff (!rst_n) !(in_ch.ready && out_ch.valid))
        else $error("input accepted while a result is pending");

    // a reused index never comes with a vertex overflow
    assert property (@(posedge clk) disable iff (!rst_n)
        out_ch.valid |-> !(out_ch.reused && out_ch.vertex_overflow))
        else $error("reused and overflow both set");

    // a hit ends the scan
    assert property (@(posedge clk) disable iff (!rst_n) status.hit |=> !cmd.cmp)
        else $error("scan continued after a match");
endmodule
